### src/aofb_pkg.sv
// Package for the AES-128 OFB byte stream core: types, S-box, round helpers.
// No dependencies.
`timescale 1ns / 1ps
package aofb_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int ROUNDS      = 10;

    typedef enum logic [2:0] {
        ST_EXPAND,
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        REG_KEY_HIGH = 2'd0,
        REG_KEY_LOW  = 2'd1,
        REG_IV_HIGH  = 2'd2,
        REG_IV_LOW   = 2'd3
    } reg_idx_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte k of a block sits at bits [127-8k -: 8]
    function automatic logic [7:0] blk_byte(input logic [127:0] b, input int k);
        return b[127 - 8 * k -: 8];
    endfunction

endpackage

### src/aofb_round.sv
// One AES-128 round (SubBytes, ShiftRows, optional MixColumns, AddRoundKey).
// Depends on aofb_pkg.
`timescale 1ns / 1ps
module aofb_round
    import aofb_pkg::*;
(
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         last_round,
    output logic [127:0] state_out
);

    logic [7:0] sb [16];
    logic [7:0] mc [16];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sb[k + 4 * c] = SBOX[blk_byte(state_in, k + 4 * ((c + k) & 3))];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                mc[4 * c + k] = sb[4 * c + k] ^ sb[4 * c] ^ sb[4 * c + 1] ^ sb[4 * c + 2]
                    ^ sb[4 * c + 3] ^ xt(sb[4 * c + k] ^ sb[4 * c + ((k + 1) & 3)]);
            end
        end
        for (int k = 0; k < 16; k++)
        begin
            state_out[127 - 8 * k -: 8] = (last_round ? sb[k] : mc[k])
                ^ round_key[127 - 8 * k -: 8];
        end
    end

endmodule

### src/aes128_ofb_byte_stream_core.sv
// Top level of the AES-128 OFB byte stream core: APB registers, key schedule,
// iterative round sequencer and byte output. Depends on aofb_pkg, aofb_round.
`timescale 1ns / 1ps
// Channel  | Direction | Handshake        | Payload
// in       | input     | in_valid/stall   | data_byte[7:0], last_byte
// out      | output    | out_valid/stall  | out_byte[7:0], last_out
// apb      | input     | psel/penable     | paddr[4:0], pwdata/prdata[63:0]
//
// While keystream bytes remain, a byte is accepted, the result formed and then
// handed over; only then is the next request taken. The first byte of every
// 16-byte block first runs the block through the shared round unit: a whitening
// step (ST_INIT), then the 10 rounds (ST_ROUND). After reset or any register
// write the key schedule is rebuilt, one round key per cycle, with input held off.
// A stalled result holds in the output register; the input is not accepted
// until that result is taken.
module aes128_ofb_byte_stream_core
    import aofb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_out
);

    logic [63:0]  key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    // round keys 1..10; round key 0 is the key register pair itself
    logic [127:0] rk_reg [1:ROUNDS];
    logic [127:0] fb_reg, fb_next;
    logic [3:0]   unused_reg, unused_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [7:0]   rc_reg, rc_next;
    state_t       state_reg, state_next;
    logic [7:0]   obyte_reg, obyte_next;
    logic         olast_reg, olast_next;
    logic         ovalid_reg, ovalid_next;
    logic [7:0]   dbyte_reg;
    logic         dlast_reg;
    logic         cfg_wr, in_acc;
    logic [127:0] round_out, rk_new, rk_prev, rk_sel;
    logic [31:0]  t_word;
    logic [3:0]   pos;
    reg_idx_t     widx;

    assign pready   = 1'b1;
    assign widx     = reg_idx_t'(paddr[4:3]);
    assign cfg_wr   = psel && penable && pwrite;
    assign in_stall = (state_reg != ST_IDLE) || ovalid_reg;
    assign in_acc   = in_valid && !in_stall;
    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign last_out  = olast_reg;

    always_comb
    begin
        unique case (widx)
            REG_KEY_HIGH: prdata = key_high_reg;
            REG_KEY_LOW:  prdata = key_low_reg;
            REG_IV_HIGH:  prdata = iv_high_reg;
            REG_IV_LOW:   prdata = iv_low_reg;
            default:      prdata = 64'd0;
        endcase
    end

    // round key selected by the counter; key 0 comes straight from the registers
    assign rk_sel = (cnt_reg == 4'd0) ? {key_high_reg, key_low_reg} : rk_reg[cnt_reg];

    // key schedule step: one round key from the previous one
    assign rk_prev = rk_sel;
    assign t_word = {SBOX[rk_prev[23:16]] ^ rc_reg, SBOX[rk_prev[15:8]],
                     SBOX[rk_prev[7:0]], SBOX[rk_prev[31:24]]};
    always_comb
    begin
        rk_new[127:96] = rk_prev[127:96] ^ t_word;
        rk_new[95:64]  = rk_prev[95:64] ^ rk_new[127:96];
        rk_new[63:32]  = rk_prev[63:32] ^ rk_new[95:64];
        rk_new[31:0]   = rk_prev[31:0] ^ rk_new[63:32];
    end

    aofb_round u_round (
        .state_in  (fb_reg),
        .round_key (rk_sel),
        .last_round(cnt_reg == 4'(ROUNDS)),
        .state_out (round_out)
    );

    assign pos = 4'(BLOCK_BYTES) - unused_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EXPAND: if (cnt_reg == 4'(ROUNDS - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (in_acc) state_next = (unused_reg == 4'd0) ? ST_INIT : ST_OUT;
            ST_INIT:   state_next = ST_ROUND;
            ST_ROUND:  if (cnt_reg == 4'(ROUNDS)) state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
        if (cfg_wr) state_next = ST_EXPAND;
    end

    // datapath outputs
    always_comb
    begin
        fb_next     = fb_reg;
        unused_next = unused_reg;
        cnt_next    = cnt_reg;
        rc_next     = rc_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg && out_stall;
        unique case (state_reg)
            ST_EXPAND:
            begin
                cnt_next = cnt_reg + 4'd1;
                rc_next  = xt(rc_reg);
            end
            ST_IDLE:   cnt_next = 4'd0;
            ST_INIT:
            begin
                fb_next  = fb_reg ^ rk_sel;
                cnt_next = 4'd1;
            end
            ST_ROUND:
            begin
                fb_next  = round_out;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(ROUNDS)) unused_next = 4'd0;
            end
            ST_OUT:
            begin
                obyte_next  = dbyte_reg ^ fb_reg[127 - 8 * pos -: 8];
                olast_next  = dlast_reg;
                ovalid_next = 1'b1;
                unused_next = unused_reg - 4'd1;
            end
            default: ;
        endcase
        if (cfg_wr)
        begin
            fb_next     = {(widx == REG_IV_HIGH) ? pwdata : iv_high_reg,
                           (widx == REG_IV_LOW)  ? pwdata : iv_low_reg};
            unused_next = 4'd0;
            cnt_next    = 4'd0;
            rc_next     = 8'h01;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_EXPAND;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            fb_reg       <= '0;
            unused_reg   <= '0;
            cnt_reg      <= '0;
            rc_reg       <= 8'h01;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fb_reg     <= fb_next;
            unused_reg <= unused_next;
            cnt_reg    <= cnt_next;
            rc_reg     <= rc_next;
            ovalid_reg <= ovalid_next;
            if (cfg_wr)
            begin
                unique case (widx)
                    REG_KEY_HIGH: key_high_reg <= pwdata;
                    REG_KEY_LOW:  key_low_reg  <= pwdata;
                    REG_IV_HIGH:  iv_high_reg  <= pwdata;
                    REG_IV_LOW:   iv_low_reg   <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        if (in_acc)
        begin
            dbyte_reg <= data_byte;
            dlast_reg <= last_byte;
        end
        if (state_reg == ST_EXPAND && !cfg_wr)
        begin
            rk_reg[cnt_reg + 4'd1] <= rk_new;
        end
    end

endmodule

### src/aofb_checker.sv
// Port-level checker for the AES-128 OFB byte stream core, bound to the top.
// Depends on the top level port list.
`timescale 1ns / 1ps
module aofb_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic pready
);

    // an accepted request is never followed by another accepted request in the next cycle
    a_no_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !(in_valid && !in_stall))
        else $error("back-to-back requests accepted");

    // a waiting result blocks the input
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted with result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind aes128_ofb_byte_stream_core aofb_checker u_aofb_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .pready(pready)
);
